@@ hdl/tmap_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tone map package
// Widths, queue depths, item type and the level threshold table.
// ============================================================================
package tmap_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int LEVEL_W       = 8;
    localparam int LEVELS        = 255;
    localparam int SEARCH_STAGES = LEVEL_W;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DEPTH     = 2;
    localparam int OUT_PTR_W     = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [SAMPLE_W-1:0] POS_INF   = 32'h7F80_0000;
    localparam logic [SAMPLE_W-1:0] SEARCH_LO = 32'h3080_0000;
    localparam logic [SAMPLE_W-1:0] SEARCH_HI = 32'h4480_0000;

    localparam int WIDE_W = 384;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] bits;
    } tmap_item_t;

    typedef logic [SAMPLE_W-1:0] thresh_table_t [0:LEVELS];

    // Exact level test: m^5 * 510^11 >= (2k-1)^11 * (m+d)^5
    function automatic logic tmap_reaches(input logic [SAMPLE_W-1:0] bits, input int k);
        logic [WIDE_W-1:0] m;
        logic [WIDE_W-1:0] md;
        logic [WIDE_W-1:0] p510;
        logic [WIDE_W-1:0] pk;
        logic [WIDE_W-1:0] lhs;
        logic [WIDE_W-1:0] rhs;
        int                sh;
        m    = WIDE_W'(bits[22:0]) | (WIDE_W'(1) << 23);
        sh   = 150 - int'(bits[30:23]);
        md   = m + (WIDE_W'(1) << sh);
        p510 = WIDE_W'(1);
        pk   = WIDE_W'(1);
        for (int i = 0; i < 11; i++)
        begin
            p510 = p510 * WIDE_W'(510);
            pk   = pk * WIDE_W'(2 * k - 1);
        end
        lhs = m * m * m * m * m * p510;
        rhs = md * md * md * md * md * pk;
        return lhs >= rhs;
    endfunction

    // Binary search each threshold with the exact test; thresholds rise with k
    function automatic thresh_table_t tmap_build_thresh();
        thresh_table_t       tbl;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] mid;
        tbl[0] = '0;
        lo     = SEARCH_LO;
        for (int k = 1; k <= LEVELS; k++)
        begin
            hi = SEARCH_HI;
            while (hi - lo > SAMPLE_W'(1))
            begin
                mid = lo + ((hi - lo) >> 1);
                if (tmap_reaches(mid, k))
                    hi = mid;
                else
                    lo = mid;
            end
            tbl[k] = hi;
            lo     = hi - SAMPLE_W'(1);
        end
        return tbl;
    endfunction

    localparam thresh_table_t THRESH = tmap_build_thresh();

endpackage

@@ hdl/tmap_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tone map front end
// Input register; maps negative, NaN and negative-zero samples to zero.
// ============================================================================
module tmap_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tmap_pkg::SAMPLE_W-1:0] sample_bits,
    output tmap_pkg::tmap_item_t          out_item,
    input  logic                          out_ready
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [tmap_pkg::SAMPLE_W-1:0] bits_reg;
    logic                          accept;
    logic                          drop;

    assign full   = valid_reg & ~out_ready;
    assign accept = push & ~full;
    assign drop   = sample_bits[tmap_pkg::SAMPLE_W-1] | (sample_bits > tmap_pkg::POS_INF);

    assign valid_next = accept | (valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            bits_reg <= drop ? '0 : sample_bits;
    end

    assign out_item.valid = valid_reg;
    assign out_item.bits  = bits_reg;

endmodule

@@ hdl/tmap_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tone map sample queue
// Short FIFO between the front end and the threshold search.
// ============================================================================
module tmap_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tmap_pkg::tmap_item_t wr_item,
    output logic                 wr_ready,
    output tmap_pkg::tmap_item_t rd_item,
    input  logic                 rd_ready
);

    logic [tmap_pkg::SAMPLE_W-1:0]    mem_reg [0:tmap_pkg::QUEUE_DEPTH-1];
    logic [tmap_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [tmap_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [tmap_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [tmap_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [tmap_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [tmap_pkg::QUEUE_CNT_W-1:0] count_next;
    logic                             wr_en;
    logic                             rd_en;

    localparam logic [tmap_pkg::QUEUE_PTR_W-1:0] LAST =
        tmap_pkg::QUEUE_PTR_W'(tmap_pkg::QUEUE_DEPTH - 1);

    assign wr_ready      = count_reg != tmap_pkg::QUEUE_CNT_W'(tmap_pkg::QUEUE_DEPTH);
    assign rd_item.valid = count_reg != '0;
    assign rd_item.bits  = mem_reg[rd_ptr_reg];
    assign wr_en         = wr_item.valid & wr_ready;
    assign rd_en         = rd_item.valid & rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_item.bits;
    end

endmodule

@@ hdl/tmap_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tone map back end
// Pipelined binary search over the level thresholds, one index bit per
// stage, followed by a small result FIFO.
// ============================================================================
module tmap_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmap_pkg::tmap_item_t         in_item,
    output logic                         in_ready,
    output logic                         empty,
    input  logic                         pop,
    output logic [tmap_pkg::LEVEL_W-1:0] display_value
);

    localparam int S = tmap_pkg::SEARCH_STAGES;

    logic                          stage_valid_reg [0:S-1];
    logic [tmap_pkg::LEVEL_W-1:0]  stage_idx_reg   [0:S-1];
    logic [tmap_pkg::SAMPLE_W-1:0] stage_bits_reg  [0:S-2];

    logic [tmap_pkg::LEVEL_W-1:0]   out_mem_reg [0:tmap_pkg::OUT_DEPTH-1];
    logic [tmap_pkg::OUT_PTR_W-1:0] out_wr_ptr_reg;
    logic [tmap_pkg::OUT_PTR_W-1:0] out_wr_ptr_next;
    logic [tmap_pkg::OUT_PTR_W-1:0] out_rd_ptr_reg;
    logic [tmap_pkg::OUT_PTR_W-1:0] out_rd_ptr_next;
    logic [tmap_pkg::OUT_CNT_W-1:0] out_count_reg;
    logic [tmap_pkg::OUT_CNT_W-1:0] out_count_next;

    logic advance;
    logic out_wr_en;
    logic pop_en;

    localparam logic [tmap_pkg::OUT_PTR_W-1:0] OUT_LAST =
        tmap_pkg::OUT_PTR_W'(tmap_pkg::OUT_DEPTH - 1);

    assign pop_en    = pop & ~empty;
    assign advance   = ~stage_valid_reg[S-1]
                     | (out_count_reg != tmap_pkg::OUT_CNT_W'(tmap_pkg::OUT_DEPTH))
                     | pop_en;
    assign out_wr_en = stage_valid_reg[S-1] & advance;
    assign in_ready  = advance;

    for (genvar s = 0; s < S; s++)
    begin : g_stage
        logic                          src_valid;
        logic [tmap_pkg::SAMPLE_W-1:0] src_bits;
        logic [tmap_pkg::LEVEL_W-1:0]  src_idx;
        logic [tmap_pkg::LEVEL_W-1:0]  probe;
        logic                          hit;

        if (s == 0)
        begin : g_first
            assign src_valid = in_item.valid;
            assign src_bits  = in_item.bits;
            assign src_idx   = '0;
        end
        else
        begin : g_rest
            assign src_valid = stage_valid_reg[s-1];
            assign src_bits  = stage_bits_reg[s-1];
            assign src_idx   = stage_idx_reg[s-1];
        end

        assign probe = src_idx | (tmap_pkg::LEVEL_W'(1) << (S - 1 - s));
        assign hit   = tmap_pkg::THRESH[probe] <= src_bits;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stage_valid_reg[s] <= 1'b0;
            else if (advance)
                stage_valid_reg[s] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
                stage_idx_reg[s] <= hit ? probe : src_idx;
        end

        if (s < S - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (advance)
                    stage_bits_reg[s] <= src_bits;
            end
        end
    end

    // result FIFO
    always_comb
    begin
        out_wr_ptr_next = out_wr_ptr_reg;
        out_rd_ptr_next = out_rd_ptr_reg;
        if (out_wr_en)
            out_wr_ptr_next = (out_wr_ptr_reg == OUT_LAST) ? '0 : out_wr_ptr_reg + 1'b1;
        if (pop_en)
            out_rd_ptr_next = (out_rd_ptr_reg == OUT_LAST) ? '0 : out_rd_ptr_reg + 1'b1;
        unique case ({out_wr_en, pop_en})
            2'b10:   out_count_next = out_count_reg + 1'b1;
            2'b01:   out_count_next = out_count_reg - 1'b1;
            default: out_count_next = out_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            out_wr_ptr_reg <= out_wr_ptr_next;
            out_rd_ptr_reg <= out_rd_ptr_next;
            out_count_reg  <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr_en)
            out_mem_reg[out_wr_ptr_reg] <= stage_idx_reg[S-1];
    end

    assign empty         = out_count_reg == '0;
    assign display_value = out_mem_reg[out_rd_ptr_reg];

endmodule

@@ hdl/hdr_reinhard_gamma_tonemap_top.sv @@
`timescale 1ns / 1ps
// Path: input register, sample queue, search stages, result FIFO, in that order.
// Throughput: one sample per cycle through the 8-stage search unless output stalls.
// Storage: 15 samples in flight (input register, 4-entry queue, 8 stages, 2 results).
// Reset: rst_n clears all queues and valid flags at once; the threshold table
// is constant, so the block takes samples right after reset.
// ============================================================================
// HDR Reinhard tone map with gamma 2.2, top level
// Maps one float32 channel sample to an 8-bit display value.
// ============================================================================
module hdr_reinhard_gamma_tonemap_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tmap_pkg::SAMPLE_W-1:0] sample_bits,
    output logic                          empty,
    input  logic                          pop,
    output logic [tmap_pkg::LEVEL_W-1:0]  display_value
);

    tmap_pkg::tmap_item_t front_item;
    tmap_pkg::tmap_item_t queue_item;
    logic                 queue_wr_ready;
    logic                 back_ready;

    tmap_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_bits (sample_bits),
        .out_item    (front_item),
        .out_ready   (queue_wr_ready)
    );

    tmap_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_ready (queue_wr_ready),
        .rd_item  (queue_item),
        .rd_ready (back_ready)
    );

    tmap_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_item       (queue_item),
        .in_ready      (back_ready),
        .empty         (empty),
        .pop           (pop),
        .display_value (display_value)
    );

endmodule

@@ hdl/tmap_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tone map port checker
// Tracks samples in flight from the ports and checks occupancy and output hold.
// ============================================================================
module tmap_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         push,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic [tmap_pkg::LEVEL_W-1:0] display_value
);

    localparam int CAPACITY = 1 + tmap_pkg::QUEUE_DEPTH + tmap_pkg::SEARCH_STAGES
                            + tmap_pkg::OUT_DEPTH;
    localparam int CNT_W    = $clog2(CAPACITY + 2);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = push & ~full;
    assign out_xfer = pop & ~empty;

    always_comb
    begin
        unique case ({in_xfer, out_xfer})
            2'b10:   inflight_next = inflight_reg + 1'b1;
            2'b01:   inflight_next = inflight_reg - 1'b1;
            default: inflight_next = inflight_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(display_value)))
        else $error("result changed or vanished before transfer");

    a_empty_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == '0) |-> empty)
        else $error("result shown with no sample in flight");

    a_full_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (inflight_reg >= CNT_W'(1 + tmap_pkg::QUEUE_DEPTH)))
        else $error("full raised while front queue has room");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(CAPACITY))
        else $error("more samples in flight than storage");

endmodule

bind hdr_reinhard_gamma_tonemap_top tmap_checker u_checker (.*);
